// ===== hdl/cfr_pkg.sv =====
// shared types and constants for the chunk frame reassembler
// no dependencies; imported by the top level, cfr_ctrl, cfr_datapath and cfr_checker

package cfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int ACT_W      = 2;
    localparam int WORD_BYTES = 8;
    localparam int WORD_W     = WORD_BYTES * BYTE_W;
    localparam int POS_W      = $clog2(WORD_BYTES);
    localparam int BIW_W      = 4;
    localparam int FLEN_W     = 9;
    localparam int IDX_W      = 8;

    localparam logic [ACT_W-1:0] ACT_HEADER = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DATA   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic item_en;
        logic rd_issue;
        logic emit_empty;
    } cmd_t;

    typedef struct packed {
        logic frame_done;
        logic frame_empty;
        logic rd_last;
    } status_t;

endpackage

// ===== hdl/chunk_frame_reassembler_unit.sv =====
// top level of the chunk frame reassembler
// depends on cfr_pkg, cfr_ctrl, cfr_datapath
//
//   channel | handshake                | payload
//   --------+--------------------------+----------------------------------------------
//   input   | start, busy (start&!busy)| action, sequence_req, chunk_index,
//           |                          | chunk_total, chunk_length, data_byte
//   output  | word_valid (one cycle)   | frame_word, bytes_in_word, frame_length,
//           |                          | final_word
//
// header, data and clear words are taken without raising busy, but
// a word that completes a non-empty frame of L bytes holds busy high during readout:
// the frame store has one read port and gives one byte per cycle
// the last output word appears in the first cycle in which busy is low again;
// an empty frame's word appears in the cycle after its completing input word
// reset clears all control state at once; the frame store needs no clearing pass

module chunk_frame_reassembler_unit #(
    parameter int FRAME_BYTES = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [cfr_pkg::ACT_W-1:0]  action,
    input  logic [cfr_pkg::BYTE_W-1:0] sequence_req,
    input  logic [cfr_pkg::IDX_W-1:0]  chunk_index,
    input  logic [cfr_pkg::IDX_W-1:0]  chunk_total,
    input  logic [cfr_pkg::BYTE_W-1:0] chunk_length,
    input  logic [cfr_pkg::BYTE_W-1:0] data_byte,
    output logic                       word_valid,
    output logic [cfr_pkg::WORD_W-1:0] frame_word,
    output logic [cfr_pkg::BIW_W-1:0]  bytes_in_word,
    output logic [cfr_pkg::FLEN_W-1:0] frame_length,
    output logic                       final_word
);

    import cfr_pkg::*;

    cmd_t    cmd;
    status_t status;

    cfr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .status(status),
        .cmd   (cmd)
    );

    cfr_datapath #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .action       (action),
        .sequence_req (sequence_req),
        .chunk_index  (chunk_index),
        .chunk_total  (chunk_total),
        .chunk_length (chunk_length),
        .data_byte    (data_byte),
        .word_valid   (word_valid),
        .frame_word   (frame_word),
        .bytes_in_word(bytes_in_word),
        .frame_length (frame_length),
        .final_word   (final_word)
    );

endmodule

// ===== hdl/cfr_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
// no dependencies

module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/cfr_ctrl.sv =====
// controller: accepts items and sequences the frame readout burst
// depends on cfr_pkg

module cfr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  cfr_pkg::status_t status,
    output cfr_pkg::cmd_t    cmd
);

    import cfr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.item_en && status.frame_done && !status.frame_empty)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (status.rd_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy           = 1'b1;
        cmd.item_en    = 1'b0;
        cmd.rd_issue   = 1'b0;
        cmd.emit_empty = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy           = 1'b0;
                cmd.item_en    = start;
                cmd.emit_empty = start && status.frame_done && status.frame_empty;
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
            end
            ST_DRAIN:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== hdl/cfr_datapath.sv =====
// datapath: chunk bookkeeping, frame store and 64-bit word assembly
// depends on cfr_pkg and cfr_ram

module cfr_datapath #(
    parameter int FRAME_BYTES = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfr_pkg::cmd_t                 cmd,
    output cfr_pkg::status_t              status,
    input  logic [cfr_pkg::ACT_W-1:0]     action,
    input  logic [cfr_pkg::BYTE_W-1:0]    sequence_req,
    input  logic [cfr_pkg::IDX_W-1:0]     chunk_index,
    input  logic [cfr_pkg::IDX_W-1:0]     chunk_total,
    input  logic [cfr_pkg::BYTE_W-1:0]    chunk_length,
    input  logic [cfr_pkg::BYTE_W-1:0]    data_byte,
    output logic                          word_valid,
    output logic [cfr_pkg::WORD_W-1:0]    frame_word,
    output logic [cfr_pkg::BIW_W-1:0]     bytes_in_word,
    output logic [cfr_pkg::FLEN_W-1:0]    frame_length,
    output logic                          final_word
);

    import cfr_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int LW = $clog2(FRAME_BYTES + 1);
    localparam int SW = ((LW > BYTE_W) ? LW : BYTE_W) + 1;

    // chunk bookkeeping
    logic              open_reg, open_next;
    logic [BYTE_W-1:0] seq_reg, seq_next;
    logic [IDX_W-1:0]  tot_reg, tot_next;
    logic [IDX_W-1:0]  exp_reg, exp_next;
    logic [LW-1:0]     len_reg, len_next;
    logic [BYTE_W-1:0] left_reg, left_next;
    logic              done;
    logic              store_we;

    // readout
    logic [LW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic              rd_pend_reg;
    logic [LW-1:0]     rx_reg, rx_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [WORD_W-1:0] asm_reg, asm_base, asm_new;
    logic [BYTE_W-1:0] rdata;
    logic              last_byte;
    logic              emit_word;

    logic              valid_reg;
    logic [WORD_W-1:0] fw_reg;
    logic [BIW_W-1:0]  biw_reg;
    logic [FLEN_W-1:0] flen_reg;
    logic              fin_reg;

    always_comb
    begin
        logic              e_open;
        logic [BYTE_W-1:0] e_seq;
        logic [IDX_W-1:0]  e_tot;
        logic [IDX_W-1:0]  e_exp;
        logic [LW-1:0]     e_len;
        logic [IDX_W:0]    exp_inc;

        open_next = open_reg;
        seq_next  = seq_reg;
        tot_next  = tot_reg;
        exp_next  = exp_reg;
        len_next  = len_reg;
        left_next = left_reg;
        done      = 1'b0;
        store_we  = 1'b0;
        e_open    = open_reg;
        e_seq     = seq_reg;
        e_tot     = tot_reg;
        e_exp     = exp_reg;
        e_len     = len_reg;
        exp_inc   = {1'b0, exp_reg} + (IDX_W + 1)'(1);

        if (cmd.item_en)
        begin
            case (action)
                ACT_CLEAR:
                begin
                    open_next = 1'b0;
                    seq_next  = '0;
                    tot_next  = '0;
                    exp_next  = '0;
                    len_next  = '0;
                    left_next = '0;
                end
                ACT_HEADER:
                begin
                    if (chunk_total != '0)
                    begin
                        // header inside an unfinished chunk aborts the frame
                        if (left_reg != '0)
                        begin
                            e_open    = 1'b0;
                            left_next = '0;
                        end
                        if (chunk_index == '0)
                        begin
                            e_open = 1'b1;
                            e_seq  = sequence_req;
                            e_tot  = chunk_total;
                            e_exp  = '0;
                            e_len  = '0;
                        end
                        open_next = e_open;
                        seq_next  = e_seq;
                        tot_next  = e_tot;
                        exp_next  = e_exp;
                        len_next  = e_len;
                        exp_inc   = {1'b0, e_exp} + (IDX_W + 1)'(1);
                        if (e_open)
                        begin
                            if (sequence_req != e_seq || chunk_index != e_exp
                                || chunk_total != e_tot)
                            begin
                                open_next = 1'b0;
                            end
                            else if (SW'(e_len) + SW'(chunk_length) > SW'(FRAME_BYTES))
                            begin
                                open_next = 1'b0;
                            end
                            else
                            begin
                                left_next = chunk_length;
                                if (chunk_length == '0)
                                begin
                                    exp_next = exp_inc[IDX_W-1:0];
                                    if (exp_inc >= {1'b0, e_tot})
                                    begin
                                        open_next = 1'b0;
                                        done      = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                ACT_DATA:
                begin
                    if (open_reg && left_reg != '0)
                    begin
                        store_we  = len_reg < LW'(FRAME_BYTES);
                        len_next  = len_reg + LW'(1);
                        left_next = left_reg - BYTE_W'(1);
                        if (left_reg == BYTE_W'(1))
                        begin
                            exp_next = exp_inc[IDX_W-1:0];
                            if (exp_inc >= {1'b0, tot_reg})
                            begin
                                open_next = 1'b0;
                                done      = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign status.frame_done  = done;
    assign status.frame_empty = (len_next == '0);
    assign status.rd_last     = (rd_ptr_reg + LW'(1) == len_reg);

    cfr_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(FRAME_BYTES)
    ) u_store (
        .clk  (clk),
        .we   (store_we),
        .waddr(len_reg[AW-1:0]),
        .wdata(data_byte),
        .raddr(rd_ptr_reg[AW-1:0]),
        .rdata(rdata)
    );

    always_comb
    begin
        asm_base = (pos_reg == '0) ? '0 : asm_reg;
        asm_new  = asm_base;
        asm_new[{pos_reg, 3'b000} +: BYTE_W] = rdata;
    end

    assign last_byte = (rx_reg + LW'(1) == len_reg);
    assign emit_word = rd_pend_reg && (pos_reg == POS_W'(WORD_BYTES - 1) || last_byte);

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        rx_next     = rx_reg;
        pos_next    = pos_reg;
        if (cmd.item_en)
        begin
            rd_ptr_next = '0;
            rx_next     = '0;
            pos_next    = '0;
        end
        else
        begin
            if (cmd.rd_issue)
            begin
                rd_ptr_next = rd_ptr_reg + LW'(1);
            end
            if (rd_pend_reg)
            begin
                rx_next  = rx_reg + LW'(1);
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg    <= 1'b0;
            seq_reg     <= '0;
            tot_reg     <= '0;
            exp_reg     <= '0;
            len_reg     <= '0;
            left_reg    <= '0;
            rd_ptr_reg  <= '0;
            rd_pend_reg <= 1'b0;
            rx_reg      <= '0;
            pos_reg     <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            open_reg    <= open_next;
            seq_reg     <= seq_next;
            tot_reg     <= tot_next;
            exp_reg     <= exp_next;
            len_reg     <= len_next;
            left_reg    <= left_next;
            rd_ptr_reg  <= rd_ptr_next;
            rd_pend_reg <= cmd.rd_issue;
            rx_reg      <= rx_next;
            pos_reg     <= pos_next;
            valid_reg   <= emit_word || cmd.emit_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            asm_reg <= asm_new;
        end
        if (emit_word)
        begin
            fw_reg   <= asm_new;
            biw_reg  <= BIW_W'(pos_reg) + BIW_W'(1);
            flen_reg <= FLEN_W'(len_reg);
            fin_reg  <= last_byte;
        end
        else if (cmd.emit_empty)
        begin
            fw_reg   <= '0;
            biw_reg  <= '0;
            flen_reg <= '0;
            fin_reg  <= 1'b1;
        end
    end

    assign word_valid    = valid_reg;
    assign frame_word    = fw_reg;
    assign bytes_in_word = biw_reg;
    assign frame_length  = flen_reg;
    assign final_word    = fin_reg;

endmodule

// ===== hdl/cfr_checker.sv =====
// port-level checks for the chunk frame reassembler, bound to the top level
// depends on cfr_pkg and chunk_frame_reassembler_unit

module cfr_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       word_valid,
    input logic [cfr_pkg::WORD_W-1:0] frame_word,
    input logic [cfr_pkg::BIW_W-1:0]  bytes_in_word,
    input logic [cfr_pkg::FLEN_W-1:0] frame_length,
    input logic                       final_word
);

    import cfr_pkg::*;

    // only the last word of a frame may be short
    a_full_words: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !final_word |-> bytes_in_word == BIW_W'(WORD_BYTES))
        else $error("non-final word is not full");

    // empty word belongs to an empty frame
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && bytes_in_word == '0 |->
            final_word && frame_length == '0 && frame_word == '0)
        else $error("empty word with stray content");

    // unused high bytes of a single-byte word are zero
    a_single_byte: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && bytes_in_word == BIW_W'(1) |-> frame_word[WORD_W-1:BYTE_W] == '0)
        else $error("unused bytes not zero");

    // more words of the frame are pending, so the block is busy
    a_busy_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !final_word |-> busy)
        else $error("idle in the middle of a frame");

    // readout starts only after an accepted word
    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start) && !word_valid)
        else $error("busy rose without a completing word");

endmodule

bind chunk_frame_reassembler_unit cfr_checker u_cfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .word_valid   (word_valid),
    .frame_word   (frame_word),
    .bytes_in_word(bytes_in_word),
    .frame_length (frame_length),
    .final_word   (final_word)
);
